// ----- hdl/bba_pkg.sv -----
// Package for the buddy block allocator: pool size, status codes, header codes, widths.
// No dependencies.
package bba_pkg;
   localparam int TOP_BLOCKS  = 10;
   localparam int NUM_CLASSES = 7;
   localparam logic [2:0] ST_ALLOC    = 3'd0;
   localparam logic [2:0] ST_NOSPACE  = 3'd1;
   localparam logic [2:0] ST_ILLEGAL  = 3'd2;
   localparam logic [2:0] ST_RETURNED = 3'd3;
   localparam logic [2:0] ST_NOTREC   = 3'd4;
   localparam logic [2:0] ST_DOUBLE   = 3'd5;
   localparam logic [3:0] HDR_NONE    = 4'd0;
   localparam logic [3:0] HDR_ALLOC   = 4'd8;

   typedef logic [3:0] hdr_type;

   // Header code of a free block of class cls (0 = largest).
   function automatic hdr_type free_code(input logic [2:0] cls);
      free_code = {1'b0, cls + 3'd1};
   endfunction
endpackage

// ----- hdl/bba_hdr_ram.sv -----
// Block header store: one 4-bit header per minimum-size slot, registered read.
// Depends on bba_pkg.
module bba_hdr_ram
   import bba_pkg::*;
#(
   parameter int DEPTH = 640,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  hdr_type       wr_data,
   input  logic [AW-1:0] rd_addr,
   output hdr_type       rd_data
);
   hdr_type mem [DEPTH];
   hdr_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ----- hdl/buddy_block_allocator_top.sv -----
// Buddy block allocator over TOP_BLOCKS top blocks of 512 words, block sizes
// 512 down to 8 words. After reset a clearing pass writes every header slot,
// one per cycle; req_ready stays low meanwhile. One beat is handled by a
// sequencer around a single header memory with one registered read port: a
// request scans free headers class by class, from its own class up to the
// 512-word class, reading and checking each slot visited, then splits one
// level per cycle and marks the block allocated; a return reads and checks its
// header, then merges one level at a time (read and check the lower half, read
// and check the upper half, write the merged header). An illegal size or a bad
// index goes straight to the result. Results, free counts and the tight flag
// sit in an output register so a new beat may be taken while the last result
// waits; a finished item holds in its final state, with req_ready low, until
// that register frees up.
// Depends on bba_pkg and bba_hdr_ram.
module buddy_block_allocator_top
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [9:0]  req_request_words,
   input  logic [12:0] req_block_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [12:0] rsp_alloc_index,
   output logic        rsp_tight,
   output logic [3:0]  rsp_free_512,
   output logic [4:0]  rsp_free_256,
   output logic [5:0]  rsp_free_128,
   output logic [6:0]  rsp_free_64,
   output logic [7:0]  rsp_free_32,
   output logic [8:0]  rsp_free_16,
   output logic [9:0]  rsp_free_8,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_tight_threshold
);
   localparam int SLOTS = TOP_BLOCKS * 64;
   localparam int AW    = $clog2(SLOTS);
   localparam int POOL  = TOP_BLOCKS * 512;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_SCAN      = 4'd2;
   localparam logic [3:0] S_SCHK      = 4'd3;
   localparam logic [3:0] S_SPLIT     = 4'd4;
   localparam logic [3:0] S_RRD       = 4'd5;
   localparam logic [3:0] S_RCHK      = 4'd6;
   localparam logic [3:0] S_MRD1      = 4'd7;
   localparam logic [3:0] S_MRD2      = 4'd8;
   localparam logic [3:0] S_MCHK      = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;
   localparam logic [3:0] S_MCHK_WAIT = 4'd11;
   localparam logic [3:0] S_MERGE_W   = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [AW:0]   pos_ff, pos_in;        // slot cursor, one extra bit for the end
   logic [AW-1:0] bud_ff, bud_in;
   logic [2:0]    cls_ff, cls_in;        // class being scanned / merged
   logic [2:0]    tgt_ff, tgt_in;
   hdr_type       h1_ff, h1_in;
   logic [2:0]    stat_ff, stat_in;
   logic [9:0]    cnt_ff [NUM_CLASSES];
   logic [9:0]    cnt_in [NUM_CLASSES];
   logic          tight_ff, tight_in;
   logic [3:0]    thr_ff;
   logic          ov_ff, ov_in;          // output register full
   logic [2:0]    os_ff;
   logic [12:0]   oi_ff;
   logic          ot_ff;
   logic [9:0]    oc_ff [NUM_CLASSES];
   logic          load;

   logic          we;
   logic [AW-1:0] wa, ra;
   hdr_type       wd, rd;

   bba_hdr_ram #(.DEPTH(SLOTS), .AW(AW)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   // Stride in slots of class c: 64 >> c.
   function automatic logic [AW:0] stride(input logic [2:0] c);
      stride = (AW+1)'(7'd64 >> c);
   endfunction

   // Target class for a request: smallest block with size >= r+1, >= 8 words.
   function automatic logic [2:0] target(input logic [9:0] r);
      logic [10:0] need;
      logic [2:0]  t;
      need = {1'b0, r} + 11'd1;
      t = 3'd0;
      for (int k = 1; k < NUM_CLASSES; k++) begin
         if ((11'd512 >> k) >= need) begin
            t = 3'(k);
         end
      end
      target = t;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      bud_in   = bud_ff;
      cls_in   = cls_ff;
      tgt_in   = tgt_ff;
      h1_in    = h1_ff;
      stat_in  = stat_ff;
      cnt_in   = cnt_ff;
      tight_in = tight_ff;
      load     = 1'b0;
      we       = 1'b0;
      wa       = pos_ff[AW-1:0];
      wd       = HDR_NONE;
      ra       = pos_ff[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            // Write a free top header at each top-block boundary, none elsewhere.
            we = 1'b1;
            wd = (pos_ff[5:0] == 6'd0) ? free_code(3'd0) : HDR_NONE;
            pos_in = pos_ff + (AW+1)'(1);
            if (pos_ff == (AW+1)'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               pos_in = '0;
               if (!req_mode) begin
                  if (req_request_words > 10'd511) begin
                     stat_in  = ST_ILLEGAL;
                     state_in = S_DONE;
                  end else begin
                     tgt_in   = target(req_request_words);
                     cls_in   = target(req_request_words);
                     state_in = S_SCAN;
                  end
               end else if ({1'b0, req_block_index} >= 14'(POOL)
                            || req_block_index[2:0] != 3'd0) begin
                  stat_in  = ST_NOTREC;
                  state_in = S_DONE;
               end else begin
                  pos_in   = (AW+1)'(req_block_index[12:3]);
                  state_in = S_RRD;
               end
            end
         end
         S_SCAN: begin
            // Issue the read of slot pos_ff.
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (rd == free_code(cls_ff)) begin
               state_in = S_SPLIT;
            end else if (pos_ff + stride(cls_ff) >= (AW+1)'(SLOTS)) begin
               pos_in = '0;
               if (cls_ff == 3'd0) begin
                  stat_in  = ST_NOSPACE;
                  state_in = S_DONE;
               end else begin
                  cls_in   = cls_ff - 3'd1;
                  state_in = S_SCAN;
               end
            end else begin
               pos_in   = pos_ff + stride(cls_ff);
               state_in = S_SCAN;
            end
         end
         S_SPLIT: begin
            // Per cycle: mark the upper half free at the next class, or finish.
            we = 1'b1;
            if (cls_ff < tgt_ff) begin
               wa = pos_ff[AW-1:0] + AW'(stride(cls_ff + 3'd1));
               wd = free_code(cls_ff + 3'd1);
               cnt_in[cls_ff]        = cnt_ff[cls_ff] - 10'd1;
               cnt_in[cls_ff + 3'd1] = cnt_ff[cls_ff + 3'd1] + 10'd2;
               cls_in = cls_ff + 3'd1;
            end else begin
               wd = HDR_ALLOC | free_code(tgt_ff);
               cnt_in[tgt_ff] = cnt_ff[tgt_ff] - 10'd1;
               stat_in  = ST_ALLOC;
               state_in = S_DONE;
            end
         end
         S_RRD: begin
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if (rd[2:0] == 3'd0) begin
               stat_in  = ST_NOTREC;
               state_in = S_DONE;
            end else if (!rd[3]) begin
               stat_in  = ST_DOUBLE;
               state_in = S_DONE;
            end else begin
               cls_in = rd[2:0] - 3'd1;
               we     = 1'b1;
               wd     = free_code(rd[2:0] - 3'd1);
               cnt_in[rd[2:0] - 3'd1] = cnt_ff[rd[2:0] - 3'd1] + 10'd1;
               stat_in  = ST_RETURNED;
               state_in = S_MRD1;
            end
         end
         S_MRD1: begin
            // Find the buddy pair; read the lower half first.
            h1_in = HDR_NONE;
            if (cls_ff == 3'd0) begin
               state_in = S_DONE;
            end else begin
               if ((pos_ff & stride(cls_ff)) == '0) begin
                  bud_in = pos_ff[AW-1:0] + AW'(stride(cls_ff));
               end else begin
                  bud_in = pos_ff[AW-1:0];
                  pos_in = pos_ff - stride(cls_ff);
               end
               if ((pos_ff & stride(cls_ff)) == '0
                   && pos_ff + stride(cls_ff) >= (AW+1)'(SLOTS)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MRD2;
               end
            end
         end
         S_MRD2: begin
            ra       = pos_ff[AW-1:0];
            state_in = S_MCHK;
         end
         S_MCHK: begin
            // First pass: rd holds the lower header; if it is free, h1 is set and the
            // upper header is read through S_MCHK_WAIT for a second pass.
            ra = bud_ff;
            if (h1_ff == HDR_ALLOC) begin
               // Second pass: rd holds the upper header.
               if (rd == free_code(cls_ff)) begin
                  we = 1'b1;
                  wa = bud_ff;
                  wd = HDR_NONE;
                  cnt_in[cls_ff]        = cnt_ff[cls_ff] - 10'd2;
                  cnt_in[cls_ff - 3'd1] = cnt_ff[cls_ff - 3'd1] + 10'd1;
                  cls_in   = cls_ff - 3'd1;
                  h1_in    = HDR_NONE;
                  state_in = S_MERGE_W;
               end else begin
                  state_in = S_DONE;
               end
            end else if (rd == free_code(cls_ff)) begin
               h1_in    = HDR_ALLOC;
               state_in = S_MCHK_WAIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MCHK_WAIT: begin
            ra       = bud_ff;
            state_in = S_MCHK;
         end
         S_MERGE_W: begin
            we       = 1'b1;
            wd       = free_code(cls_ff);
            state_in = S_MRD1;
         end
         S_DONE: begin
            // Hold here while the output register still has an untaken beat.
            if (!ov_ff || rsp_ready) begin
               if (cnt_ff[0] < {6'd0, thr_ff}) begin
                  tight_in = 1'b1;
               end
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ov_in = load ? 1'b1 : (rsp_ready ? 1'b0 : ov_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pos_ff   <= '0;
         tight_ff <= 1'b0;
         thr_ff   <= 4'd2;
         ov_ff    <= 1'b0;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_ff[k] <= (k == 0) ? 10'(TOP_BLOCKS) : 10'd0;
         end
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         tight_ff <= tight_in;
         ov_ff    <= ov_in;
         cnt_ff   <= cnt_in;
         if (csr_valid) begin
            thr_ff <= csr_tight_threshold;
         end
      end
      bud_ff  <= bud_in;
      cls_ff  <= cls_in;
      tgt_ff  <= tgt_in;
      h1_ff   <= h1_in;
      stat_ff <= stat_in;
      if (load) begin
         os_ff <= stat_ff;
         oi_ff <= (stat_ff == ST_ALLOC) ? {pos_ff[AW-1:0], 3'b000} : 13'd0;
         ot_ff <= tight_in;
         oc_ff <= cnt_ff;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_status      = os_ff;
   assign rsp_alloc_index = oi_ff;
   assign rsp_tight       = ot_ff;
   assign rsp_free_512    = oc_ff[0][3:0];
   assign rsp_free_256    = oc_ff[1][4:0];
   assign rsp_free_128    = oc_ff[2][5:0];
   assign rsp_free_64     = oc_ff[3][6:0];
   assign rsp_free_32     = oc_ff[4][7:0];
   assign rsp_free_16     = oc_ff[5][8:0];
   assign rsp_free_8      = oc_ff[6];
endmodule

// ----- test/bba_checker.sv -----
// Checker for the buddy block allocator: watches request, response and csr beats,
// predicts every response with its own allocator copy and compares field by field.
// Depends on bba_pkg.
module bba_checker
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [9:0]  req_request_words,
   input  logic [12:0] req_block_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [12:0] rsp_alloc_index,
   input  logic        rsp_tight,
   input  logic [3:0]  rsp_free_512,
   input  logic [4:0]  rsp_free_256,
   input  logic [5:0]  rsp_free_128,
   input  logic [6:0]  rsp_free_64,
   input  logic [7:0]  rsp_free_32,
   input  logic [8:0]  rsp_free_16,
   input  logic [9:0]  rsp_free_8,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_tight_threshold,
   output int          fail_count,
   output int          pending
);
   localparam int TOPS = 10;
   localparam int SLOTS = TOPS * 64;

   typedef struct packed {
      logic [2:0]  status;
      logic [12:0] index;
      logic        tight;
      logic [3:0]  f512;
      logic [4:0]  f256;
      logic [5:0]  f128;
      logic [6:0]  f64;
      logic [7:0]  f32;
      logic [8:0]  f16;
      logic [9:0]  f8;
   } alloc_result_type;

   hdr_type          headers [SLOTS];
   int               counts [NUM_CLASSES];
   logic             tight_q;
   logic [3:0]       threshold;
   alloc_result_type expected_q[$];

   function automatic hdr_type fcode(int cls);
      return hdr_type'(cls + 1);
   endfunction

   function automatic alloc_result_type predict_alloc(logic mode, logic [9:0] words,
                                                      logic [12:0] idx);
      alloc_result_type r;
      int target, need, s, cls, stride, pos, half, lo, up, sl, wds;
      logic [2:0] st;
      logic found;
      r = '0;
      r.index = '0;
      found = 1'b0;
      if (!mode) begin
         if (words > 511) begin
            st = ST_ILLEGAL;
         end else begin
            st = ST_NOSPACE;
            target = 0; need = words + 1; s = 512;
            while (target + 1 < NUM_CLASSES && (s >> 1) >= need && (s >> 1) >= 8) begin
               s = s >> 1;
               target++;
            end
            for (int c = target; c >= 0 && !found; c--) begin
               stride = (512 >> c) / 8;
               for (pos = 0; pos < SLOTS && !found; pos += stride) begin
                  if (headers[pos] == fcode(c)) begin
                     found = 1'b1;
                     cls = c;
                     while (cls < target) begin
                        half = (512 >> (cls + 1)) / 8;
                        headers[pos] = fcode(cls + 1);
                        headers[pos + half] = fcode(cls + 1);
                        counts[cls] -= 1;
                        counts[cls + 1] += 2;
                        cls++;
                     end
                     headers[pos] = HDR_ALLOC | fcode(target);
                     counts[target] -= 1;
                     r.index = 13'(pos * 8);
                     st = ST_ALLOC;
                  end
               end
            end
         end
      end else begin
         if (idx >= TOPS * 512 || idx[2:0] != 0) begin
            st = ST_NOTREC;
         end else begin
            pos = idx / 8;
            if (headers[pos][2:0] == 0) st = ST_NOTREC;
            else if (!headers[pos][3]) st = ST_DOUBLE;
            else begin
               cls = headers[pos][2:0] - 1;
               if (cls >= NUM_CLASSES) st = ST_NOTREC;
               else begin
                  st = ST_RETURNED;
                  headers[pos] = fcode(cls);
                  counts[cls] += 1;
                  while (cls > 0) begin
                     wds = 512 >> cls;
                     sl = wds / 8;
                     if (((pos * 8) % (2 * wds)) == 0) begin
                        lo = pos; up = pos + sl;
                     end else begin
                        lo = pos - sl; up = pos;
                     end
                     if (up >= SLOTS) break;
                     if (headers[lo] != fcode(cls) || headers[up] != fcode(cls)) break;
                     headers[up] = HDR_NONE;
                     headers[lo] = fcode(cls - 1);
                     counts[cls] -= 2;
                     counts[cls - 1] += 1;
                     pos = lo;
                     cls--;
                  end
               end
            end
         end
      end
      if (counts[0] < threshold) tight_q = 1'b1;
      r.status = st;
      if (st != ST_ALLOC) r.index = '0;
      r.tight = tight_q;
      r.f512 = 4'(counts[0]);  r.f256 = 5'(counts[1]); r.f128 = 6'(counts[2]);
      r.f64 = 7'(counts[3]);   r.f32 = 8'(counts[4]);  r.f16 = 9'(counts[5]);
      r.f8 = 10'(counts[6]);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) headers[i] = (i % 64 == 0) ? fcode(0) : HDR_NONE;
         for (int k = 0; k < NUM_CLASSES; k++) counts[k] = (k == 0) ? TOPS : 0;
         tight_q = 1'b0;
         threshold = 4'd2;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold = csr_tight_threshold;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_alloc_index, rsp_tight, rsp_free_512, rsp_free_256,
                    rsp_free_128, rsp_free_64, rsp_free_32, rsp_free_16, rsp_free_8};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected st=%0d idx=%0d t=%0d f=%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                           $time, want.status, want.index, want.tight, want.f512, want.f256,
                           want.f128, want.f64, want.f32, want.f16, want.f8);
                  $display("%0t:          actual   st=%0d idx=%0d t=%0d f=%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                           $time, got.status, got.index, got.tight, got.f512, got.f256,
                           got.f128, got.f64, got.f32, got.f16, got.f8);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_alloc(req_mode, req_request_words, req_block_index));
      end
      pending <= expected_q.size();
   end
endmodule

// ----- test/buddy_block_allocator_top_tb.sv -----
// Testbench top for the buddy block allocator: drives request, response-ready
// and csr beats and gives the verdict. Depends on bba_pkg, bba_checker and the DUT.
module buddy_block_allocator_top_tb
   import bba_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [9:0]  req_request_words = '0;
   logic [12:0] req_block_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [12:0] rsp_alloc_index;
   logic        rsp_tight;
   logic [3:0]  rsp_free_512;
   logic [4:0]  rsp_free_256;
   logic [5:0]  rsp_free_128;
   logic [6:0]  rsp_free_64;
   logic [7:0]  rsp_free_32;
   logic [8:0]  rsp_free_16;
   logic [9:0]  rsp_free_8;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_tight_threshold = '0;
   int          fail_count;
   int          pending;

   // Live allocations, tracked from response beats so returns hit real blocks.
   logic [12:0] live_blocks[$];
   logic        quiet_phase = 1'b0;
   logic        hold_rsp = 1'b0;

   buddy_block_allocator_top DUT (.*);

   bba_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Harvest allocated block addresses from accepted response beats.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == ST_ALLOC)
         live_blocks.push_back(rsp_alloc_index);
   end

   // Receiver: random stall bursts, a long hold-off on request, none at the end.
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one request beat; hold it until accepted.
   task automatic send_beat(input logic mode, input logic [9:0] words,
                            input logic [12:0] idx);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_request_words <= words;
      req_block_index <= idx;
      do @(posedge clock); while (!req_ready);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Drain: drop valid, wait for all responses, then pad for any in-flight work.
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_tight_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic release_random();
      int k;
      k = $urandom_range(0, live_blocks.size() - 1);
      send_beat(1'b1, 10'($urandom), live_blocks[k]);
      live_blocks.delete(k);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // mostly small sizes keep scans short
         send_beat(1'b0, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 511))
                                                   : 10'($urandom_range(0, 70)),
                   13'($urandom));
      end else if (pick < 75 && live_blocks.size() > 0) begin
         release_random();
      end else if (pick < 82) begin
         send_beat(1'b0, 10'($urandom_range(512, 1023)), 13'($urandom));
      end else if (pick < 88 && live_blocks.size() > 0) begin
         // return a live block twice: second one reports already free, or not recorded if merged away
         send_beat(1'b1, 10'($urandom), live_blocks[0]);
         send_beat(1'b1, 10'($urandom), live_blocks[0]);
         void'(live_blocks.pop_front());
      end else begin
         send_beat(1'b1, 10'($urandom), 13'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, illegal sizes, bad and double returns.
      send_beat(1'b0, 10'd0, 13'h1fff);
      send_beat(1'b0, 10'd7, '0);
      send_beat(1'b0, 10'd8, '0);
      send_beat(1'b0, 10'd255, '0);
      send_beat(1'b0, 10'd256, '0);
      send_beat(1'b0, 10'd511, '0);
      send_beat(1'b0, 10'd512, '0);
      send_beat(1'b0, 10'd1023, '0);
      send_beat(1'b1, '0, 13'd8191);
      send_beat(1'b1, '0, 13'd5120);
      send_beat(1'b1, '0, 13'd3);
      send_beat(1'b1, '0, 13'd4600);
      drain_all();
      while (live_blocks.size() > 0) begin
         send_beat(1'b1, 10'h3ff, live_blocks[0]);
         send_beat(1'b1, 10'h3ff, live_blocks[0]);
         void'(live_blocks.pop_front());
      end
      // exhaust the pool with top blocks, then one more gives no space
      for (int i = 0; i < 11; i++) send_beat(1'b0, 10'd300, '0);
      drain_all();

      // Phases over several thresholds, extremes among them.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_threshold(4'd0);
            1: write_threshold(4'd10);
            2: write_threshold(4'd15);
            3: write_threshold(4'd5);
            4: write_threshold(4'd1);
            default: write_threshold(4'd3);
         endcase
         if (ph == 2) hold_rsp = 1'b1;
         if (ph == 5) quiet_phase = 1'b1;
         for (int n = 0; n < 310; n++) random_item();
         drain_all();
      end

      if (fail_count == 0)
         $display("buddy_block_allocator_top regression: pass");
      else
         $display("buddy_block_allocator_top regression: fail");
      $finish;
   end

   initial begin
      #250000000;
      $display("buddy_block_allocator_top regression: fail");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/bba_pkg.sv
hdl/bba_hdr_ram.sv
hdl/buddy_block_allocator_top.sv
test/bba_checker.sv
test/buddy_block_allocator_top_tb.sv
